>>> rtl/atwm_pkg.sv
// shared types, codes and the weighted-minute function for the active time window meter
// no dependencies; imported by every module of the block
package atwm_pkg;

  localparam int STAMP_W = 34;
  localparam int MIN_W   = 32;
  localparam int DATA_W  = 64;
  localparam int ADDR_W  = 4;

  localparam logic [31:0] YEAR_MIN  = 32'd525960;
  localparam logic [31:0] MONTH_MIN = 32'd43800;
  localparam logic [31:0] DAY_MIN   = 32'd1440;
  localparam logic [31:0] HOUR_MIN  = 32'd60;

  // register select is paddr bit 3 (8-byte spacing)
  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_END   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_OTHER = 2'd2
  } kind_t;

  typedef struct packed {
    logic             in_range;
    logic [1:0]       kind;
    logic             last;
    logic [MIN_W-1:0] stamp_min;
  } item_t;

  function automatic logic [MIN_W-1:0] weighted_minutes(input logic [STAMP_W-1:0] packed_stamp);
    logic [31:0] yr, mo, dy, hr, mi;
    yr = {18'd0, packed_stamp[33:20]};
    mo = {28'd0, packed_stamp[19:16]};
    dy = {27'd0, packed_stamp[15:11]};
    hr = {27'd0, packed_stamp[10:6]};
    mi = {26'd0, packed_stamp[5:0]};
    return 32'(YEAR_MIN * yr) + 32'(MONTH_MIN * mo) + 32'(DAY_MIN * dy)
           + 32'(HOUR_MIN * hr) + mi;
  endfunction

endpackage

>>> rtl/atwm_front.sv
// front stage: takes event words, packs the stamp, checks the window and weights the stamp
// depends on atwm_pkg
module atwm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [13:0]                    stamp_year,
  input  logic [3:0]                     stamp_month,
  input  logic [4:0]                     stamp_day,
  input  logic [4:0]                     stamp_hour,
  input  logic [5:0]                     stamp_minute,
  input  logic [1:0]                     event_kind,
  input  logic                           last_entry,
  input  logic [atwm_pkg::STAMP_W-1:0]   window_start,
  input  logic [atwm_pkg::STAMP_W-1:0]   window_end,
  output logic                           item_valid,
  output atwm_pkg::item_t                item,
  input  logic                           item_stall
);
  import atwm_pkg::*;

  logic [STAMP_W-1:0] stamp;
  logic               take;

  assign stamp    = {stamp_year, stamp_month, stamp_day, stamp_hour, stamp_minute};
  assign in_stall = item_valid && item_stall;
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (!item_stall) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.in_range  <= (stamp >= window_start) && (stamp <= window_end);
      item.kind      <= event_kind;
      item.last      <= last_entry;
      item.stamp_min <= weighted_minutes(stamp);
    end
  end

endmodule

>>> rtl/atwm_queue.sv
// two-entry queue between the front and back stages
// depends on atwm_pkg
module atwm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  atwm_pkg::item_t push_item,
  output logic            pop_valid,
  output atwm_pkg::item_t pop_item,
  input  logic            pop_stall
);
  import atwm_pkg::*;

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_stall = (count == 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_item;
  end

endmodule

>>> rtl/atwm_back.sv
// back stage: on/off tracking, minute accumulation and the result register
// depends on atwm_pkg
module atwm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  input  atwm_pkg::item_t              item,
  output logic                         item_stall,
  input  logic [atwm_pkg::MIN_W-1:0]   start_min,
  input  logic [atwm_pkg::MIN_W-1:0]   end_min,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         in_window,
  output logic                         event_taken,
  output logic                         total_valid,
  output logic signed [31:0]           active_minutes
);
  import atwm_pkg::*;

  typedef enum logic [1:0] {
    PH_FRESH,
    PH_ON,
    PH_OFF
  } phase_t;

  phase_t           phase;
  phase_t           phase_next;
  logic [MIN_W-1:0] ref_min;
  logic [MIN_W-1:0] ref_next;
  logic [MIN_W-1:0] total;
  logic [MIN_W-1:0] total_mid;
  logic [MIN_W-1:0] total_next;
  logic [MIN_W-1:0] ref_used;
  logic [MIN_W-1:0] end_ref;
  logic             take_on;
  logic             take_off;
  logic             pop;

  assign item_stall = out_valid && out_stall;
  assign pop        = item_valid && !item_stall;

  always_comb begin
    take_on    = item.in_range && (item.kind == KIND_ON)  && (phase != PH_ON);
    take_off   = item.in_range && (item.kind == KIND_OFF) && (phase != PH_OFF);
    ref_used   = (phase == PH_FRESH) ? start_min : ref_min;
    total_mid  = take_off ? total + (item.stamp_min - ref_used) : total;
    phase_next = take_on ? PH_ON : (take_off ? PH_OFF : phase);
    end_ref    = take_on ? item.stamp_min : ref_used;
    ref_next   = take_on ? item.stamp_min : ref_min;
    // still on at the final entry: count up to the window end
    total_next = (item.last && phase_next == PH_ON) ? total_mid + (end_min - end_ref)
                                                    : total_mid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FRESH;
      ref_min   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
      if (item.last) begin
        phase   <= PH_FRESH;
        ref_min <= '0;
        total   <= '0;
      end else begin
        phase   <= phase_next;
        ref_min <= ref_next;
        total   <= total_next;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      in_window      <= item.in_range;
      event_taken    <= take_on || take_off;
      total_valid    <= item.last;
      active_minutes <= $signed(total_next);
    end
  end

endmodule

>>> rtl/active_time_window_meter_core.sv
// active time window meter: each event goes front register, queue, back result register
// one event word per cycle while out_stall is low; the back stage next state is combinational
// the two-entry queue lets the front keep taking words through a short output stall
// rst (synchronous) clears the window registers to 0, the queue and the on/off tracking
// window weights are registered, settling the cycle after a window register takes a write
// depends on atwm_pkg, atwm_front, atwm_queue, atwm_back
module active_time_window_meter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atwm_pkg::ADDR_W-1:0]   paddr,
  input  logic [atwm_pkg::DATA_W-1:0]   pwdata,
  output logic [atwm_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [13:0]                   stamp_year,
  input  logic [3:0]                    stamp_month,
  input  logic [4:0]                    stamp_day,
  input  logic [4:0]                    stamp_hour,
  input  logic [5:0]                    stamp_minute,
  input  logic [1:0]                    event_kind,
  input  logic                          last_entry,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          in_window,
  output logic                          event_taken,
  output logic                          total_valid,
  output logic signed [31:0]            active_minutes
);
  import atwm_pkg::*;

  logic [STAMP_W-1:0] window_start;
  logic [STAMP_W-1:0] window_end;
  logic [MIN_W-1:0]   start_min;
  logic [MIN_W-1:0]   end_min;
  logic               cfg_write;
  logic               front_valid;
  item_t              front_item;
  logic               front_stall;
  logic               back_valid;
  item_t              back_item;
  logic               back_stall;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_WINDOW_START: window_start <= pwdata[STAMP_W-1:0];
        REG_WINDOW_END:   window_end   <= pwdata[STAMP_W-1:0];
        default:          window_start <= window_start;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_WINDOW_START: prdata = {{(DATA_W-STAMP_W){1'b0}}, window_start};
      REG_WINDOW_END:   prdata = {{(DATA_W-STAMP_W){1'b0}}, window_end};
      default:          prdata = '0;
    endcase
  end

  // window bounds in weighted minutes, kept off the event path
  always_ff @(posedge clk) begin
    start_min <= weighted_minutes(window_start);
    end_min   <= weighted_minutes(window_end);
  end

  atwm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .stamp_year   (stamp_year),
    .stamp_month  (stamp_month),
    .stamp_day    (stamp_day),
    .stamp_hour   (stamp_hour),
    .stamp_minute (stamp_minute),
    .event_kind   (event_kind),
    .last_entry   (last_entry),
    .window_start (window_start),
    .window_end   (window_end),
    .item_valid   (front_valid),
    .item         (front_item),
    .item_stall   (front_stall)
  );

  atwm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_stall (front_stall),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_item   (back_item),
    .pop_stall  (back_stall)
  );

  atwm_back u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (back_valid),
    .item           (back_item),
    .item_stall     (back_stall),
    .start_min      (start_min),
    .end_min        (end_min),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .in_window      (in_window),
    .event_taken    (event_taken),
    .total_valid    (total_valid),
    .active_minutes (active_minutes)
  );

endmodule
